// ===== rtl/smm_pkg.sv =====
`default_nettype none

package smm_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 4;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 36;
  localparam int DIM_W  = 5;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2
  } smm_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } smm_state_e;

  typedef enum logic [1:0] {
    RSP_OK,
    RSP_ERR,
    RSP_ACC
  } smm_rsp_sel_e;

  typedef logic [DIM_W-1:0] smm_dim_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] element;
  } smm_req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] product_value;
    logic                    status;
  } smm_rsp_t;

  typedef struct packed {
    logic         start;
    logic         issue;
    logic         write_a;
    logic         write_b;
    logic         rsp_load;
    smm_rsp_sel_e rsp_sel;
  } smm_ctrl_t;

  typedef struct packed {
    logic pipe_busy;
  } smm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/smm_stream_if.sv =====
`default_nettype none

interface smm_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/square_matrix_multiply.sv =====
// Channel  Role  Payload                            Beat taken when
// request  in    command, row, col, element         request.valid && request.ready
// result   out   product_value, status              result.valid && result.ready
// cfg      in    dim (5 bits)                       cfg.valid && cfg.ready
//
// A write or a rejected item gets its result the next cycle.
// A product makes one read of each operand memory per term, feeding
// a single multiply-accumulate unit through a three-stage pipeline.
// Reset clears the controller and sets dim to 16; operand memories are not cleared.
// A new item is taken only while idle and the result register is empty or being read.
`default_nettype none

module square_matrix_multiply
  import smm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input wire logic     clk,
  input wire logic     rst,
  smm_stream_if.sink   request,
  smm_stream_if.source result,
  smm_stream_if.sink   cfg
);

  smm_ctrl_t ctrl;
  smm_stat_t stat;
  smm_req_t  req;
  smm_rsp_t  rsp;
  smm_dim_t  cfg_dim;

  assign req       = request.payload;
  assign cfg_dim   = cfg.payload;
  assign cfg.ready = 1'b1;
  assign result.payload = rsp;

  smm_controller #(
    .MAX_DIM(MAX_DIM)
  ) u_controller (
    .clk      (clk),
    .rst      (rst),
    .req_valid(request.valid),
    .req_ready(request.ready),
    .req      (req),
    .rsp_valid(result.valid),
    .rsp_ready(result.ready),
    .cfg_valid(cfg.valid),
    .cfg_dim  (cfg_dim),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  smm_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .ctrl(ctrl),
    .stat(stat),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/smm_datapath.sv =====
`default_nettype none

module smm_datapath
  import smm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire smm_ctrl_t ctrl,
  output smm_stat_t      stat,
  input  wire smm_req_t  req,
  output smm_rsp_t       rsp
);

  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic signed [ELEM_W-1:0] left_mem  [MEM_DEPTH];
  logic signed [ELEM_W-1:0] right_mem [MEM_DEPTH];

  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            a_addr;
  logic [AW-1:0]            b_addr;
  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     rd_valid;
  logic                     prod_valid;

  assign wr_addr = AW'(32'(req.row) * MAX_DIM + 32'(req.col));

  always_ff @(posedge clk) begin
    if (ctrl.write_a) begin
      left_mem[wr_addr] <= req.element;
    end
    if (ctrl.write_b) begin
      right_mem[wr_addr] <= req.element;
    end
    if (ctrl.issue) begin
      a_q <= left_mem[a_addr];
      b_q <= right_mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a_addr <= AW'(32'(req.row) * MAX_DIM);
      b_addr <= AW'(req.col);
    end else if (ctrl.issue) begin
      a_addr <= a_addr + AW'(1);
      b_addr <= b_addr + AW'(MAX_DIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= ctrl.issue;
      prod_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prod <= a_q * b_q;
    end
    if (ctrl.start) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rsp_load) begin
      case (ctrl.rsp_sel)
        RSP_OK: begin
          rsp.product_value <= '0;
          rsp.status        <= STATUS_OK;
        end
        RSP_ACC: begin
          rsp.product_value <= acc;
          rsp.status        <= STATUS_OK;
        end
        default: begin
          rsp.product_value <= '0;
          rsp.status        <= STATUS_ERR;
        end
      endcase
    end
  end

  assign stat.pipe_busy = rd_valid | prod_valid;

endmodule

`default_nettype wire

// ===== rtl/smm_controller.sv =====
`default_nettype none

module smm_controller
  import smm_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire smm_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  input  wire logic     cfg_valid,
  input  wire smm_dim_t cfg_dim,
  output smm_ctrl_t     ctrl,
  input  wire smm_stat_t stat
);

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  smm_state_e       state;
  smm_state_e       state_next;
  smm_dim_t         dim;
  logic [CNT_W-1:0] dim_eff;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] cnt_inc;
  logic             slot_free;
  logic             bad_index;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= DIM_RESET;
    end else if (cfg_valid) begin
      dim <= cfg_dim;
    end
  end

  always_comb begin
    if (32'(dim) > 32'(MAX_DIM)) begin
      dim_eff = CNT_W'(MAX_DIM);
    end else begin
      dim_eff = CNT_W'(dim);
    end
  end

  assign slot_free = !rsp_valid || rsp_ready;
  assign bad_index = (32'(req.row) >= 32'(dim_eff)) || (32'(req.col) >= 32'(dim_eff));
  assign cnt_inc   = cnt + CNT_W'(1);
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (ctrl.rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    req_ready     = 1'b0;
    ctrl.start    = 1'b0;
    ctrl.issue    = 1'b0;
    ctrl.write_a  = 1'b0;
    ctrl.write_b  = 1'b0;
    ctrl.rsp_load = 1'b0;
    ctrl.rsp_sel  = RSP_OK;
    case (state)
      ST_IDLE: begin
        req_ready = slot_free;
        if (accept) begin
          if (bad_index) begin
            ctrl.rsp_load = 1'b1;
            ctrl.rsp_sel  = RSP_ERR;
          end else begin
            case (req.command)
              CMD_WRITE_A: begin
                ctrl.write_a  = 1'b1;
                ctrl.rsp_load = 1'b1;
              end
              CMD_WRITE_B: begin
                ctrl.write_b  = 1'b1;
                ctrl.rsp_load = 1'b1;
              end
              CMD_COMPUTE: begin
                ctrl.start = 1'b1;
                cnt_next   = '0;
                state_next = ST_RUN;
              end
              default: begin
                ctrl.rsp_load = 1'b1;
                ctrl.rsp_sel  = RSP_ERR;
              end
            endcase
          end
        end
      end
      ST_RUN: begin
        ctrl.issue = 1'b1;
        cnt_next   = cnt_inc;
        if (cnt_inc == dim_eff) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          ctrl.rsp_load = 1'b1;
          ctrl.rsp_sel  = RSP_ACC;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
